@@ src/sra_pkg.sv @@
// Package with sizes and register indexes for the substring replace block.
package sra_pkg;

    // Largest pattern and replacement in bytes
    localparam int MAX_PATTERN_BYTES     = 8;
    localparam int MAX_REPLACEMENT_BYTES = 8;

    // Result buffer depth: one input byte causes at most this many results
    localparam int RES_DEPTH = (MAX_PATTERN_BYTES > MAX_REPLACEMENT_BYTES) ?
                               MAX_PATTERN_BYTES : MAX_REPLACEMENT_BYTES;

    // Width of the length registers, fill and result counts
    localparam int LEN_W  = 4;
    localparam int DATA_W = 64;
    localparam int ADDR_W = 2;

    // Configuration register indexes
    typedef enum logic [ADDR_W-1:0] {
        CFG_PATTERN_BYTES     = 2'd0,
        CFG_PATTERN_LEN       = 2'd1,
        CFG_REPLACEMENT_BYTES = 2'd2,
        CFG_REPLACEMENT_LEN   = 2'd3
    } cfg_index_t;

    typedef logic [7:0] byte_t;

endpackage

@@ src/substring_replace_all.sv @@
// Streaming find-and-replace-all over a byte string.
//
// Input: one byte per transaction on s_tdata[7:0], s_tlast marks the final
// byte of a string. Output: one result per transaction; m_tdata[7:0] is the
// byte, m_tlast marks the last result caused by one input byte, m_tuser[0]
// is has_byte (0 for a bare end marker) and m_tuser[1] marks the final
// result of the whole string.
// The pattern, its length, the replacement and its length are set through
// cfg_we / cfg_addr / cfg_wdata while the block is idle; writing the pattern
// length discards any bytes held in the window.
// Results of an input byte appear on the cycle after it is taken. The
// result buffer drains one byte per cycle while the receiver is ready; a
// byte that causes several results is not followed by a new byte until the
// last is taken; with one result per byte and no stall the block takes a
// byte every cycle. A byte that only fills the window shows nothing.
// Reset (aresetn low, synchronous) zeroes the config registers and empties
// the window and result buffer. When the receiver stalls, the current
// result holds and s_tready drops until the last buffered result is taken.
module substring_replace_all (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Configuration write port
    input  logic                       cfg_we,
    input  logic [sra_pkg::ADDR_W-1:0] cfg_addr,
    input  logic [sra_pkg::DATA_W-1:0] cfg_wdata,
    // Input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] data_byte
    input  logic                       s_tlast,   // last_byte
    // Result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // [7:0] out_byte
    output logic                       m_tlast,   // run_last
    output logic [1:0]                 m_tuser    // [0] has_byte, [1] end_of_string
);
    import sra_pkg::*;

    localparam int WIN_DEPTH = MAX_PATTERN_BYTES;
    localparam logic [LEN_W-1:0] MAX_PAT_LEN = LEN_W'(MAX_PATTERN_BYTES);
    localparam logic [LEN_W-1:0] MAX_REP_LEN = LEN_W'(MAX_REPLACEMENT_BYTES);

    // Configuration registers
    logic [DATA_W-1:0] pattern_bytes_reg;
    logic [LEN_W-1:0]  pattern_len_reg;
    logic [DATA_W-1:0] replacement_bytes_reg;
    logic [LEN_W-1:0]  replacement_len_reg;

    // Window state
    byte_t            win_reg  [WIN_DEPTH];
    byte_t            win_next [WIN_DEPTH];
    logic [LEN_W-1:0] fill_reg;
    logic [LEN_W-1:0] fill_next;

    // Result buffer, head at entry 0
    byte_t            res_byte_reg  [RES_DEPTH];
    byte_t            res_byte_next [RES_DEPTH];
    logic [LEN_W-1:0] res_cnt_reg;
    logic [LEN_W-1:0] res_cnt_next;
    logic             res_has_reg;
    logic             res_has_next;
    logic             res_eos_reg;

    // Working values
    logic [LEN_W-1:0] plen;
    logic [LEN_W-1:0] rlen;
    byte_t            win_ins [WIN_DEPTH];
    logic [LEN_W-1:0] fill_ins;
    logic             full;
    logic             match;
    logic             s_accept;
    logic             m_accept;

    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;

    // Take a new byte when the buffer is empty or its last result leaves now
    assign s_tready = (res_cnt_reg == '0) ||
                      ((res_cnt_reg == LEN_W'(1)) && m_tready);

    assign m_tvalid   = (res_cnt_reg != '0);
    assign m_tdata    = res_byte_reg[0];
    assign m_tlast    = (res_cnt_reg == LEN_W'(1));
    assign m_tuser[0] = res_has_reg;
    assign m_tuser[1] = m_tlast && res_eos_reg;

    // Clamp lengths to their maximum
    assign plen = (pattern_len_reg > MAX_PAT_LEN) ? MAX_PAT_LEN : pattern_len_reg;
    assign rlen = (replacement_len_reg > MAX_REP_LEN) ? MAX_REP_LEN : replacement_len_reg;

    // Insert the incoming byte and compare the window with the pattern
    always_comb begin
        for (int j = 0; j < WIN_DEPTH; j++) begin
            win_ins[j] = ((fill_reg == LEN_W'(j)) && (fill_reg < plen)) ?
                         s_tdata : win_reg[j];
        end
        fill_ins = (fill_reg < plen) ? fill_reg + LEN_W'(1) : fill_reg;
        full     = (fill_ins >= plen);
        match    = 1'b1;
        for (int j = 0; j < WIN_DEPTH; j++) begin
            if ((LEN_W'(j) < plen) && (win_ins[j] != pattern_bytes_reg[8*j +: 8])) begin
                match = 1'b0;
            end
        end
    end

    // Build the results of one input byte and the next window
    always_comb begin
        for (int j = 0; j < RES_DEPTH; j++) begin
            res_byte_next[j] = '0;
        end
        res_cnt_next = '0;
        res_has_next = 1'b1;
        fill_next    = fill_reg;
        for (int j = 0; j < WIN_DEPTH; j++) begin
            win_next[j] = win_reg[j];
        end

        if (plen == '0) begin
            // Pass through
            res_byte_next[0] = s_tdata;
            res_cnt_next     = LEN_W'(1);
        end else begin
            for (int j = 0; j < WIN_DEPTH; j++) begin
                win_next[j] = win_ins[j];
            end
            if (full && match) begin
                // Emit the replacement and clear the window
                for (int j = 0; j < RES_DEPTH; j++) begin
                    if ((j < MAX_REPLACEMENT_BYTES) && (LEN_W'(j) < rlen)) begin
                        res_byte_next[j] = replacement_bytes_reg[8*j +: 8];
                    end
                end
                res_cnt_next = rlen;
                fill_next    = '0;
            end else if (s_tlast) begin
                // Flush the whole window in order
                for (int j = 0; j < RES_DEPTH; j++) begin
                    if ((j < WIN_DEPTH) && (LEN_W'(j) < fill_ins)) begin
                        res_byte_next[j] = win_ins[j];
                    end
                end
                res_cnt_next = fill_ins;
                fill_next    = '0;
            end else if (full) begin
                // Emit the oldest byte and slide
                res_byte_next[0] = win_ins[0];
                res_cnt_next     = LEN_W'(1);
                for (int j = 0; j < WIN_DEPTH - 1; j++) begin
                    win_next[j] = win_ins[j+1];
                end
                fill_next = fill_ins - LEN_W'(1);
            end else begin
                fill_next = fill_ins;
            end
        end

        // Bare end marker when the final byte leaves nothing to show
        if (s_tlast && (res_cnt_next == '0)) begin
            res_has_next = 1'b0;
            res_cnt_next = LEN_W'(1);
        end
    end

    // Configuration registers and window fill
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_bytes_reg     <= '0;
            pattern_len_reg       <= '0;
            replacement_bytes_reg <= '0;
            replacement_len_reg   <= '0;
            fill_reg              <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index_t'(cfg_addr))
                    CFG_PATTERN_BYTES:     pattern_bytes_reg <= cfg_wdata;
                    CFG_PATTERN_LEN: begin
                        pattern_len_reg <= cfg_wdata[LEN_W-1:0];
                    end
                    CFG_REPLACEMENT_BYTES: replacement_bytes_reg <= cfg_wdata;
                    CFG_REPLACEMENT_LEN:   replacement_len_reg <= cfg_wdata[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (cfg_we && (cfg_index_t'(cfg_addr) == CFG_PATTERN_LEN)) begin
                fill_reg <= '0;
            end else if (s_accept) begin
                fill_reg <= fill_next;
            end
        end
    end

    // Window bytes hold no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int j = 0; j < WIN_DEPTH; j++) begin
                win_reg[j] <= win_next[j];
            end
        end
    end

    // Result buffer: load on accept, else shift on each output transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_cnt_reg <= '0;
        end else if (s_accept) begin
            res_cnt_reg <= res_cnt_next;
        end else if (m_accept) begin
            res_cnt_reg <= res_cnt_reg - LEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int j = 0; j < RES_DEPTH; j++) begin
                res_byte_reg[j] <= res_byte_next[j];
            end
            res_has_reg <= res_has_next;
            res_eos_reg <= s_tlast;
        end else if (m_accept) begin
            for (int j = 0; j < RES_DEPTH - 1; j++) begin
                res_byte_reg[j] <= res_byte_reg[j+1];
            end
            res_byte_reg[RES_DEPTH-1] <= '0;
        end
    end

    // Window fill stays below the largest pattern length between bytes
    a_fill_below_max: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg < MAX_PAT_LEN)
        else $error("window fill reached its maximum");

    // Buffer never exceeds its depth
    a_res_cnt_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        res_cnt_reg <= LEN_W'(RES_DEPTH))
        else $error("result buffer overflow");

    // Bare end marker is alone, zero and closes the string
    a_bare_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tuser[1] && (m_tdata == 8'd0)))
        else $error("malformed end marker");

    // No new byte is taken in the middle of a run of results
    a_no_accept_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("input taken while results remain");

    // A taken final byte always yields results flagged end of string next cycle
    a_last_gives_eos: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=> (m_tvalid && res_eos_reg))
        else $error("final byte gave no end of string");

endmodule

@@ tb/sv/substring_replace_all_checker.sv @@
// Stream checker for substring_replace_all: tracks config, predicts and compares results.
`timescale 1ns / 1ps

module substring_replace_all_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [sra_pkg::ADDR_W-1:0] cfg_addr,
    input  logic [sra_pkg::DATA_W-1:0] cfg_wdata,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] data_byte
    input  logic                       s_tlast,   // last_byte
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [7:0]                 m_tdata,   // [7:0] out_byte
    input  logic                       m_tlast,   // run_last
    input  logic [1:0]                 m_tuser,   // [0] has_byte, [1] end_of_string
    output int                         errors,
    output int                         pending
);
    import sra_pkg::*;

    typedef struct packed {
        byte_t out_byte;
        logic  has_byte;
        logic  run_last;
        logic  end_of_string;
    } text_result_t;

    // Shadow copy of the configuration registers
    logic [63:0]      pattern;
    logic [LEN_W-1:0] pattern_len;
    logic [63:0]      replacement;
    logic [LEN_W-1:0] replacement_len;

    // Shadow copy of the match window, oldest byte at index 0
    byte_t       window [MAX_PATTERN_BYTES];
    int unsigned window_fill;

    text_result_t expected_text[$];

    function automatic text_result_t make_result(input byte_t b, input logic has);
        text_result_t r;
        r.out_byte      = has ? b : 8'h00;
        r.has_byte      = has;
        r.run_last      = 1'b0;
        r.end_of_string = 1'b0;
        return r;
    endfunction

    // Work out the results that one input byte causes and queue them
    task automatic predict_replace(input byte_t b, input logic last);
        int unsigned  plen;
        int unsigned  rlen;
        logic         hit;
        text_result_t outs[$];
        plen = (pattern_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : pattern_len;
        rlen = (replacement_len > MAX_REPLACEMENT_BYTES) ?
               MAX_REPLACEMENT_BYTES : replacement_len;
        if (plen == 0) begin
            outs.insert(outs.size(), make_result(b, 1'b1));
        end else begin
            if (window_fill < plen) begin
                window[window_fill] = b;
                window_fill++;
            end
            if (window_fill >= plen) begin
                hit = 1'b1;
                for (int i = 0; i < plen; i++) begin
                    if (window[i] != pattern[8*i +: 8]) hit = 1'b0;
                end
                if (hit) begin
                    for (int i = 0; i < rlen; i++) begin
                        outs.insert(outs.size(), make_result(replacement[8*i +: 8], 1'b1));
                    end
                    window_fill = 0;
                end else begin
                    // Emit the oldest byte and slide the window
                    outs.insert(outs.size(), make_result(window[0], 1'b1));
                    for (int i = 1; i < window_fill; i++) window[i-1] = window[i];
                    window_fill--;
                end
            end
            // Flush what is left at the end of the string
            if (last) begin
                for (int i = 0; i < window_fill; i++) begin
                    outs.insert(outs.size(), make_result(window[i], 1'b1));
                end
                window_fill = 0;
            end
        end
        if (last && outs.size() == 0) outs.insert(0, make_result(8'h00, 1'b0));
        if (outs.size() > 0) begin
            outs[outs.size()-1].run_last      = 1'b1;
            outs[outs.size()-1].end_of_string = last;
        end
        foreach (outs[i]) expected_text.insert(expected_text.size(), outs[i]);
    endtask

    always @(posedge aclk) begin
        text_result_t want;
        text_result_t got;
        if (!aresetn) begin
            pattern         = '0;
            pattern_len     = '0;
            replacement     = '0;
            replacement_len = '0;
            window_fill     = 0;
            expected_text.delete();
        end else begin
            // Track register writes
            if (cfg_we) begin
                case (cfg_index_t'(cfg_addr))
                    CFG_PATTERN_BYTES: pattern = cfg_wdata;
                    CFG_PATTERN_LEN: begin
                        pattern_len = cfg_wdata[LEN_W-1:0];
                        window_fill = 0;
                    end
                    CFG_REPLACEMENT_BYTES: replacement = cfg_wdata;
                    CFG_REPLACEMENT_LEN: replacement_len = cfg_wdata[LEN_W-1:0];
                    default: ;
                endcase
            end
            // Predict on each input transaction
            if (s_tvalid && s_tready) predict_replace(s_tdata, s_tlast);
            // Compare each result transaction with the oldest expectation
            if (m_tvalid && m_tready) begin
                got.out_byte      = m_tdata;
                got.has_byte      = m_tuser[0];
                got.run_last      = m_tlast;
                got.end_of_string = m_tuser[1];
                if (expected_text.size() == 0) begin
                    $display("%0t: unexpected result byte %h has %b run_last %b eos %b",
                             $time, got.out_byte, got.has_byte, got.run_last,
                             got.end_of_string);
                    errors++;
                end else begin
                    want = expected_text.pop_front();
                    if (got.out_byte != want.out_byte || got.has_byte != want.has_byte ||
                        got.run_last != want.run_last ||
                        got.end_of_string != want.end_of_string) begin
                        $display("%0t: mismatch, expected byte %h has %b run_last %b eos %b,",
                                 $time, want.out_byte, want.has_byte, want.run_last,
                                 want.end_of_string);
                        $display("    actual byte %h has %b run_last %b eos %b",
                                 got.out_byte, got.has_byte, got.run_last,
                                 got.end_of_string);
                        errors++;
                    end
                end
            end
        end
        pending = expected_text.size();
    end

endmodule

@@ tb/sv/substring_replace_all_test.sv @@
// Top of the substring_replace_all testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module substring_replace_all_test;
    import sra_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_GAP   = 4;

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic [ADDR_W-1:0]   cfg_addr;
    logic [DATA_W-1:0]   cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;   // [7:0] data_byte
    logic                s_tlast;   // last_byte
    logic                m_tvalid;
    logic                m_tready;
    logic [7:0]          m_tdata;   // [7:0] out_byte
    logic                m_tlast;   // run_last
    logic [1:0]          m_tuser;   // [0] has_byte, [1] end_of_string

    int errors;
    int pending;
    int cycle_count;

    // Idle rates in percent and the long receiver hold request
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_req;
    bit hold_taken;
    int hold_left;

    // Current pattern as the stimulus sees it
    logic [63:0] cur_pattern;
    int          cur_plen;

    substring_replace_all uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    substring_replace_all_checker checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .errors    (errors),
        .pending   (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("substring_replace_all_test: done, errors");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready = 1'b0;
        end else begin
            if (hold_req && !hold_taken) begin
                hold_left  = LONG_HOLD;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Offer one byte, idling at random first; returns at the falling edge after the transaction
    task automatic send_byte(input byte_t b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stop offering and wait until every expected result has come and the block settles
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_GAP) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [63:0] value);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we    = 1'b0;
        if (idx == CFG_PATTERN_BYTES) cur_pattern = value;
        if (idx == CFG_PATTERN_LEN) cur_plen = (value[3:0] > 8) ? 8 : int'(value[3:0]);
    endtask

    task automatic set_config(input logic [63:0] pat, input logic [3:0] plen,
                              input logic [63:0] rep, input logic [3:0] rlen);
        drain();
        write_reg(CFG_PATTERN_BYTES, pat);
        write_reg(CFG_PATTERN_LEN, {60'd0, plen});
        write_reg(CFG_REPLACEMENT_BYTES, rep);
        write_reg(CFG_REPLACEMENT_LEN, {60'd0, rlen});
    endtask

    // Random string; with a pattern set, mostly whole or cut pattern copies and pattern bytes
    task automatic send_text(inout int sent);
        byte_t txt[$];
        int    len;
        int    pick;
        int    cut;
        len = $urandom_range(1, 10);
        while (txt.size() < len) begin
            pick = $urandom_range(0, 99);
            if (cur_plen > 0 && pick < 40) begin
                cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, cur_plen) : cur_plen;
                for (int i = 0; i < cut; i++) txt.insert(txt.size(), cur_pattern[8*i +: 8]);
            end else if (cur_plen > 0 && pick < 75) begin
                cut = $urandom_range(0, cur_plen - 1);
                txt.insert(txt.size(), cur_pattern[8*cut +: 8]);
            end else begin
                txt.insert(txt.size(), byte_t'($urandom_range(0, 255)));
            end
        end
        foreach (txt[i]) begin
            send_byte(txt[i], i == txt.size() - 1);
            sent++;
        end
    endtask

    // Random pattern byte from a small alphabet so that partial matches are common
    function automatic byte_t alpha_byte();
        case ($urandom_range(0, 4))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h61;
            3: return 8'h62;
            default: return byte_t'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        logic [63:0] pat;
        logic [63:0] rep;
        logic [3:0]  plen;
        logic [3:0]  rlen;
        int          sent;
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        cur_pattern    = '0;
        cur_plen       = 0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Pass-through at reset, field extremes
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        // Two-byte pattern, empty replacement: bare end marker and flushes
        set_config(64'h0000_0000_0000_00FF, 4'd2, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h12, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7E, 1'b1);

        // Oversized lengths act as full width: eight results from one byte
        set_config(64'h0123_4567_89AB_CDEF, 4'd15, 64'hFEDC_BA98_7654_3210, 4'd15);
        for (int i = 0; i < 8; i++) send_byte(cur_pattern[8*i +: 8], i == 7);

        // Rewrite the pattern length mid-string: held bytes are dropped
        set_config(64'h0123_4567_89AB_CDEF, 4'd3, 64'h0000_0000_0000_5A5A, 4'd2);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hCD, 1'b0);
        drain();
        write_reg(CFG_PATTERN_LEN, 64'd3);
        send_byte(8'h55, 1'b1);

        // Rewrite the pattern bytes mid-string: the window is kept
        set_config(64'h0000_0000_0000_6261, 4'd2, 64'h1122_3344_5566_7788, 4'd8);
        send_byte(8'h61, 1'b0);
        drain();
        write_reg(CFG_PATTERN_BYTES, 64'h0000_0000_0000_6361);
        send_byte(8'h63, 1'b1);

        // Random phases over the idle modes and a spread of settings
        for (int ph = 0; ph < 8; ph++) begin
            for (int i = 0; i < 8; i++) pat[8*i +: 8] = alpha_byte();
            rep = {$urandom, $urandom};
            case (ph)
                0: begin plen = 4'd8;  rlen = 4'd0;  end
                1: begin plen = 4'd15; rlen = 4'd15; end
                2: begin plen = 4'd0;  rlen = 4'd8;  end
                3: begin plen = 4'd1;  rlen = 4'd8;  end
                default: begin
                    plen = 4'($urandom_range(1, 5));
                    rlen = 4'($urandom_range(0, 8));
                end
            endcase
            if (ph == 7) begin
                pat = '1;
                rep = '0;
            end
            set_config(pat, plen, rep, rlen);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            // Hold the receiver off long enough to back the block up
            if (ph == 3) hold_req = 1'b1;
            sent = 0;
            while (sent < 32) begin
                send_text(sent);
                // Pause the sender until every result is in
                if (ph == 5 && sent >= 20 && sent < 31) drain();
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("substring_replace_all_test: done, clean");
        end else begin
            $display("substring_replace_all_test: done, errors");
        end
        $finish;
    end

endmodule
